[sv/qrs_pkg.sv]
// ----------------------------------------------------------------------------
// qrs_pkg
// Types, widths and codes shared by the quadratic root solver modules.
// ----------------------------------------------------------------------------
package qrs_pkg;

  localparam int WORD_BITS  = 32;
  localparam int FRAC_BITS  = 16;
  localparam int TOL_W      = 31;
  localparam int FIFO_DEPTH = 4;

  localparam int W    = WORD_BITS;
  localparam int DW   = 2 * W + 2;
  localparam int SW   = DW / 2;
  localparam int MW   = W + 2;
  localparam int DENW = W + 1;

  localparam logic [TOL_W-1:0] TOL_RESET = TOL_W'(66);

  typedef enum logic [2:0] {
    CLS_NONE,
    CLS_ALL,
    CLS_LIN,
    CLS_QUAD,
    CLS_ONE,
    CLS_TWO
  } cls_t;

  typedef enum logic [1:0] {
    CNT_NONE = 2'd0,
    CNT_ONE  = 2'd1,
    CNT_TWO  = 2'd2,
    CNT_ALL  = 2'd3
  } cnt_t;

  typedef struct packed {
    logic signed [W-1:0] coef_a;
    logic signed [W-1:0] coef_b;
    logic signed [W-1:0] coef_c;
  } in_t;

  typedef struct packed {
    logic [1:0]          root_count;
    logic signed [W-1:0] root_first;
    logic signed [W-1:0] root_second;
    logic                overflow;
  } out_t;

  typedef struct packed {
    cls_t         cls;
    logic [W-1:0] am;
    logic [W-1:0] bm;
    logic [W-1:0] cm;
    logic         an;
    logic         bn;
    logic         cn;
  } coef_t;

endpackage

[sv/quadratic_root_solver.sv]
// ----------------------------------------------------------------------------
// quadratic_root_solver
// Real roots of a*x^2+b*x+c in signed fixed point, tolerance based zero tests.
// pipeline: includes the bit-per-stage square root and the two bit-per-stage
//   divider lanes; Q16.16 by default
// throughput: one item per cycle while no result is held or the held result is popped
// reset: synchronous, clears all queues and pipeline valids, tolerance to 66
// ----------------------------------------------------------------------------
module quadratic_root_solver #(
  parameter int FRAC_BITS = qrs_pkg::FRAC_BITS
) (
  input  logic                      clk,
  input  logic                      rst_n,
  input  logic                      in_push,
  input  qrs_pkg::in_t              in_data,
  output logic                      in_full,
  output logic                      out_empty,
  input  logic                      out_pop,
  output qrs_pkg::out_t             out_data,
  input  logic                      cfg_valid,
  output logic                      cfg_ready,
  input  logic [qrs_pkg::TOL_W-1:0] cfg_data
);
  import qrs_pkg::*;

  localparam int TW = W + 3;
  localparam int CW = $bits(coef_t);

  logic [TOL_W-1:0] tol_r, tol_nxt;
  logic             en;

  logic             q_vld;
  coef_t            q_data;

  logic             ds_vld;
  logic [DW-1:0]    ds_dm;
  coef_t            ds_coef;

  logic             sq_vld;
  logic [SW:0]      sq_root;
  logic [CW-1:0]    sq_side;
  coef_t            sq_coef;

  logic signed [TW-1:0] nb, sr, t1, t2;
  logic [TW-1:0]        m1, m2;
  logic [MW-1:0]        num1, num2;
  logic [DENW-1:0]      den1, den2;
  logic                 neg1, neg2;
  cnt_t                 cnt;

  logic            fm_vld_r;
  logic [MW-1:0]   fm_num1_r, fm_num2_r;
  logic [DENW-1:0] fm_den1_r, fm_den2_r;
  logic            fm_neg1_r, fm_neg2_r;
  cnt_t            fm_cnt_r;

  logic            d1_vld, d2_vld, d1_ovf, d2_ovf;
  logic [W-1:0]    d1_root, d2_root;
  logic [1:0]      d1_side;
  logic            d2_live;

  logic            out_vld_r;
  out_t            out_data_r, res;

  assign cfg_ready = 1'b1;
  assign tol_nxt   = cfg_valid ? cfg_data : tol_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      tol_r <= TOL_RESET;
    end else begin
      tol_r <= tol_nxt;
    end
  end

  assign en = !out_vld_r || out_pop;

  qrs_front u_front (
    .clk     (clk),
    .rst_n   (rst_n),
    .tol     (tol_r),
    .in_push (in_push),
    .in_data (in_data),
    .in_full (in_full),
    .q_vld   (q_vld),
    .q_pop   (en),
    .q_data  (q_data)
  );

  qrs_disc #(.FRAC_BITS(FRAC_BITS)) u_disc (
    .clk      (clk),
    .rst_n    (rst_n),
    .en       (en),
    .tol      (tol_r),
    .in_vld   (q_vld),
    .in_coef  (q_data),
    .out_vld  (ds_vld),
    .out_dm   (ds_dm),
    .out_coef (ds_coef)
  );

  qrs_sqrt #(.SIDE_W(CW)) u_sqrt (
    .clk      (clk),
    .rst_n    (rst_n),
    .en       (en),
    .in_vld   (ds_vld),
    .in_x     (ds_dm),
    .in_side  (CW'(ds_coef)),
    .out_vld  (sq_vld),
    .out_root (sq_root),
    .out_side (sq_side)
  );

  assign sq_coef = coef_t'(sq_side);

  // numerators, denominators, signs and root count for the two roots
  always_comb begin
    nb = sq_coef.bn ? $signed({3'b000, sq_coef.bm}) : -$signed({3'b000, sq_coef.bm});
    sr = $signed({1'b0, sq_root});
    t1 = nb - sr;
    t2 = nb + sr;
    m1 = t1[TW-1] ? TW'(-t1) : TW'(t1);
    m2 = t2[TW-1] ? TW'(-t2) : TW'(t2);
    num2 = m2[MW-1:0];
    den2 = {sq_coef.am, 1'b0};
    neg2 = t2[TW-1] != sq_coef.an;
    num1 = '0;
    den1 = {sq_coef.am, 1'b0};
    neg1 = 1'b0;
    cnt  = CNT_NONE;
    case (sq_coef.cls)
      CLS_ALL: begin
        cnt = CNT_ALL;
      end
      CLS_LIN: begin
        cnt  = CNT_ONE;
        num1 = MW'(sq_coef.cm);
        den1 = DENW'(sq_coef.bm);
        neg1 = sq_coef.cn == sq_coef.bn;
      end
      CLS_ONE: begin
        cnt  = CNT_ONE;
        num1 = MW'(sq_coef.bm);
        neg1 = sq_coef.bn == sq_coef.an;
      end
      CLS_TWO: begin
        cnt  = CNT_TWO;
        num1 = m1[MW-1:0];
        neg1 = t1[TW-1] != sq_coef.an;
      end
      default: begin
        cnt = CNT_NONE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      fm_vld_r <= 1'b0;
    end else if (en) begin
      fm_vld_r <= sq_vld;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      fm_num1_r <= num1;
      fm_num2_r <= num2;
      fm_den1_r <= den1;
      fm_den2_r <= den2;
      fm_neg1_r <= neg1;
      fm_neg2_r <= neg2;
      fm_cnt_r  <= cnt;
    end
  end

  qrs_div #(.FRAC_BITS(FRAC_BITS), .SIDE_W(2)) u_div1 (
    .clk      (clk),
    .rst_n    (rst_n),
    .en       (en),
    .in_vld   (fm_vld_r),
    .in_num   (fm_num1_r),
    .in_den   (fm_den1_r),
    .in_neg   (fm_neg1_r),
    .in_side  (fm_cnt_r),
    .out_vld  (d1_vld),
    .out_root (d1_root),
    .out_ovf  (d1_ovf),
    .out_side (d1_side)
  );

  qrs_div #(.FRAC_BITS(FRAC_BITS), .SIDE_W(1)) u_div2 (
    .clk      (clk),
    .rst_n    (rst_n),
    .en       (en),
    .in_vld   (fm_vld_r),
    .in_num   (fm_num2_r),
    .in_den   (fm_den2_r),
    .in_neg   (fm_neg2_r),
    .in_side  (fm_cnt_r == CNT_TWO),
    .out_vld  (d2_vld),
    .out_root (d2_root),
    .out_ovf  (d2_ovf),
    .out_side (d2_live)
  );

  always_comb begin
    res.root_count  = d1_side;
    res.root_first  = '0;
    res.root_second = '0;
    res.overflow    = 1'b0;
    case (cnt_t'(d1_side))
      CNT_ONE: begin
        res.root_first  = d1_root;
        res.root_second = d1_root;
        res.overflow    = d1_ovf;
      end
      CNT_TWO: begin
        res.root_first  = d1_root;
        res.root_second = d2_root;
        res.overflow    = d1_ovf || (d2_ovf && d2_live);
      end
      default: begin
        res.overflow = 1'b0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_vld_r <= 1'b0;
    end else if (en) begin
      out_vld_r <= d1_vld && d2_vld;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      out_data_r <= res;
    end
  end

  assign out_empty = !out_vld_r;
  assign out_data  = out_data_r;

endmodule

[sv/qrs_front.sv]
// ----------------------------------------------------------------------------
// qrs_front
// Takes coefficient words, forms magnitudes, classifies them against the
// tolerance and queues them for the back end.
// ----------------------------------------------------------------------------
module qrs_front (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic [qrs_pkg::TOL_W-1:0]   tol,
  input  logic                        in_push,
  input  qrs_pkg::in_t                in_data,
  output logic                        in_full,
  output logic                        q_vld,
  input  logic                        q_pop,
  output qrs_pkg::coef_t              q_data
);
  import qrs_pkg::*;

  localparam int PW   = $clog2(FIFO_DEPTH);
  localparam int CNTW = PW + 1;
  localparam int CMPW = (W > TOL_W) ? W : TOL_W;

  function automatic logic [W-1:0] mag_of(input logic [W-1:0] raw);
    return raw[W-1] ? (~raw + W'(1)) : raw;
  endfunction

  coef_t           cf;
  coef_t           mem_r [FIFO_DEPTH];
  logic [PW-1:0]   wr_r, wr_nxt, rd_r, rd_nxt;
  logic [CNTW-1:0] cnt_r, cnt_nxt;
  logic            push_ok, pop_ok;

  always_comb begin
    cf.am = mag_of(in_data.coef_a);
    cf.bm = mag_of(in_data.coef_b);
    cf.cm = mag_of(in_data.coef_c);
    cf.an = in_data.coef_a[W-1];
    cf.bn = in_data.coef_b[W-1];
    cf.cn = in_data.coef_c[W-1];
    if (CMPW'(cf.am) <= CMPW'(tol)) begin
      if (CMPW'(cf.bm) <= CMPW'(tol)) begin
        cf.cls = (CMPW'(cf.cm) <= CMPW'(tol)) ? CLS_ALL : CLS_NONE;
      end else begin
        cf.cls = CLS_LIN;
      end
    end else begin
      cf.cls = CLS_QUAD;
    end
  end

  assign in_full = (cnt_r == CNTW'(FIFO_DEPTH));
  assign q_vld   = (cnt_r != '0);
  assign push_ok = in_push && !in_full;
  assign pop_ok  = q_pop && q_vld;
  assign q_data  = mem_r[rd_r];

  always_comb begin
    wr_nxt  = push_ok ? PW'(wr_r + PW'(1)) : wr_r;
    rd_nxt  = pop_ok ? PW'(rd_r + PW'(1)) : rd_r;
    cnt_nxt = CNTW'(cnt_r + CNTW'(push_ok) - CNTW'(pop_ok));
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_r  <= '0;
      rd_r  <= '0;
      cnt_r <= '0;
    end else begin
      wr_r  <= wr_nxt;
      rd_r  <= rd_nxt;
      cnt_r <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push_ok) begin
      mem_r[wr_r] <= cf;
    end
  end

endmodule

[sv/qrs_disc.sv]
// ----------------------------------------------------------------------------
// qrs_disc
// Split-product multipliers and the exact discriminant, with the final
// classification of quadratic items.
// ----------------------------------------------------------------------------
module qrs_disc #(
  parameter int FRAC_BITS = qrs_pkg::FRAC_BITS
) (
  input  logic                      clk,
  input  logic                      rst_n,
  input  logic                      en,
  input  logic [qrs_pkg::TOL_W-1:0] tol,
  input  logic                      in_vld,
  input  qrs_pkg::coef_t            in_coef,
  output logic                      out_vld,
  output logic [qrs_pkg::DW-1:0]    out_dm,
  output qrs_pkg::coef_t            out_coef
);
  import qrs_pkg::*;

  localparam int H = W / 2;

  logic           s1_vld_r, s2_vld_r, s3_vld_r;
  coef_t          s1_coef_r, s2_coef_r, s3_coef_r;
  logic [W-1:0]   bb_hh_r, bb_x_r, bb_ll_r;
  logic [W-1:0]   ac_hh_r, ac_hl_r, ac_lh_r, ac_ll_r;
  logic [2*W-1:0] bb_r, ac_r;
  logic [DW-1:0]  dm_r;

  logic [DW-1:0]  b2, ac4, dm, tolw;
  logic           dneg;
  cls_t           cls;
  coef_t          s3_coef_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_vld_r <= 1'b0;
      s2_vld_r <= 1'b0;
      s3_vld_r <= 1'b0;
    end else if (en) begin
      s1_vld_r <= in_vld;
      s2_vld_r <= s1_vld_r;
      s3_vld_r <= s2_vld_r;
    end
  end

  // partial products of the half words
  always_ff @(posedge clk) begin
    if (en) begin
      s1_coef_r <= in_coef;
      bb_hh_r   <= W'(in_coef.bm[W-1:H] * in_coef.bm[W-1:H]);
      bb_x_r    <= W'(in_coef.bm[W-1:H] * in_coef.bm[H-1:0]);
      bb_ll_r   <= W'(in_coef.bm[H-1:0] * in_coef.bm[H-1:0]);
      ac_hh_r   <= W'(in_coef.am[W-1:H] * in_coef.cm[W-1:H]);
      ac_hl_r   <= W'(in_coef.am[W-1:H] * in_coef.cm[H-1:0]);
      ac_lh_r   <= W'(in_coef.am[H-1:0] * in_coef.cm[W-1:H]);
      ac_ll_r   <= W'(in_coef.am[H-1:0] * in_coef.cm[H-1:0]);
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      s2_coef_r <= s1_coef_r;
      bb_r <= ((2*W)'(bb_hh_r) << W) + ((2*W)'(bb_x_r) << (H + 1)) + (2*W)'(bb_ll_r);
      ac_r <= ((2*W)'(ac_hh_r) << W) + ((2*W)'(ac_hl_r) << H)
            + ((2*W)'(ac_lh_r) << H) + (2*W)'(ac_ll_r);
    end
  end

  always_comb begin
    b2   = DW'(bb_r);
    ac4  = DW'(ac_r) << 2;
    tolw = DW'(tol) << FRAC_BITS;
    dneg = 1'b0;
    if (s2_coef_r.an != s2_coef_r.cn) begin
      dm = b2 + ac4;
    end else if (b2 >= ac4) begin
      dm = b2 - ac4;
    end else begin
      dm   = ac4 - b2;
      dneg = 1'b1;
    end
    cls = s2_coef_r.cls;
    if (s2_coef_r.cls == CLS_QUAD) begin
      if (dm <= tolw) begin
        cls = CLS_ONE;
      end else if (!dneg) begin
        cls = CLS_TWO;
      end else begin
        cls = CLS_NONE;
      end
    end
    s3_coef_nxt     = s2_coef_r;
    s3_coef_nxt.cls = cls;
  end

  always_ff @(posedge clk) begin
    if (en) begin
      s3_coef_r <= s3_coef_nxt;
      dm_r      <= dm;
    end
  end

  assign out_vld  = s3_vld_r;
  assign out_dm   = dm_r;
  assign out_coef = s3_coef_r;

endmodule

[sv/qrs_sqrt.sv]
// ----------------------------------------------------------------------------
// qrs_sqrt
// Pipelined integer square root, one result bit per stage, rounded to
// nearest in a final stage.
// ----------------------------------------------------------------------------
module qrs_sqrt #(
  parameter int SIDE_W = 8
) (
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic                   en,
  input  logic                   in_vld,
  input  logic [qrs_pkg::DW-1:0] in_x,
  input  logic [SIDE_W-1:0]      in_side,
  output logic                   out_vld,
  output logic [qrs_pkg::SW:0]   out_root,
  output logic [SIDE_W-1:0]      out_side
);
  import qrs_pkg::*;

  localparam int RW = SW + 2;

  logic              vld_r  [SW];
  logic [DW-1:0]     x_r    [SW];
  logic [RW-1:0]     rem_r  [SW];
  logic [SW-1:0]     root_r [SW];
  logic [SIDE_W-1:0] side_r [SW];

  logic              fin_vld_r;
  logic [SW:0]       fin_root_r;
  logic [SIDE_W-1:0] fin_side_r;

  for (genvar k = 0; k < SW; k++) begin : g_st
    logic              vld_i;
    logic [DW-1:0]     x_i;
    logic [RW-1:0]     rem_i, rem2, trial;
    logic [SW-1:0]     root_i;
    logic [SIDE_W-1:0] side_i;

    if (k == 0) begin : g_head
      assign vld_i  = in_vld;
      assign x_i    = in_x;
      assign rem_i  = '0;
      assign root_i = '0;
      assign side_i = in_side;
    end else begin : g_body
      assign vld_i  = vld_r[k-1];
      assign x_i    = x_r[k-1];
      assign rem_i  = rem_r[k-1];
      assign root_i = root_r[k-1];
      assign side_i = side_r[k-1];
    end

    assign rem2  = {rem_i[RW-3:0], x_i[DW-1 -: 2]};
    assign trial = {root_i, 2'b01};

    always_ff @(posedge clk) begin
      if (!rst_n) begin
        vld_r[k] <= 1'b0;
      end else if (en) begin
        vld_r[k] <= vld_i;
      end
    end

    always_ff @(posedge clk) begin
      if (en) begin
        x_r[k]    <= x_i << 2;
        side_r[k] <= side_i;
        if (rem2 >= trial) begin
          rem_r[k]  <= rem2 - trial;
          root_r[k] <= {root_i[SW-2:0], 1'b1};
        end else begin
          rem_r[k]  <= rem2;
          root_r[k] <= {root_i[SW-2:0], 1'b0};
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      fin_vld_r <= 1'b0;
    end else if (en) begin
      fin_vld_r <= vld_r[SW-1];
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      fin_side_r <= side_r[SW-1];
      fin_root_r <= (SW+1)'(root_r[SW-1])
                  + (SW+1)'(rem_r[SW-1] > RW'(root_r[SW-1]));
    end
  end

  assign out_vld  = fin_vld_r;
  assign out_root = fin_root_r;
  assign out_side = fin_side_r;

endmodule

[sv/qrs_div.sv]
// ----------------------------------------------------------------------------
// qrs_div
// Pipelined restoring divider for (num << FRAC_BITS) / den, one quotient
// bit per stage, then rounding, saturation and sign.
// ----------------------------------------------------------------------------
module qrs_div #(
  parameter int FRAC_BITS = qrs_pkg::FRAC_BITS,
  parameter int SIDE_W    = 2
) (
  input  logic                     clk,
  input  logic                     rst_n,
  input  logic                     en,
  input  logic                     in_vld,
  input  logic [qrs_pkg::MW-1:0]   in_num,
  input  logic [qrs_pkg::DENW-1:0] in_den,
  input  logic                     in_neg,
  input  logic [SIDE_W-1:0]        in_side,
  output logic                     out_vld,
  output logic [qrs_pkg::W-1:0]    out_root,
  output logic                     out_ovf,
  output logic [SIDE_W-1:0]        out_side
);
  import qrs_pkg::*;

  localparam int QW = MW + FRAC_BITS;

  logic              vld_r  [QW];
  logic [QW-1:0]     nsh_r  [QW];
  logic [QW-1:0]     q_r    [QW];
  logic [DENW-1:0]   rem_r  [QW];
  logic [DENW-1:0]   den_r  [QW];
  logic              neg_r  [QW];
  logic [SIDE_W-1:0] side_r [QW];

  logic              fin_vld_r, fin_ovf_r;
  logic [W-1:0]      fin_root_r;
  logic [SIDE_W-1:0] fin_side_r;

  for (genvar k = 0; k < QW; k++) begin : g_st
    logic              vld_i, neg_i, ge;
    logic [QW-1:0]     nsh_i, q_i;
    logic [DENW-1:0]   rem_i, den_i;
    logic [DENW:0]     r2, dif;
    logic [SIDE_W-1:0] side_i;

    if (k == 0) begin : g_head
      assign vld_i  = in_vld;
      assign nsh_i  = QW'(in_num) << FRAC_BITS;
      assign q_i    = '0;
      assign rem_i  = '0;
      assign den_i  = in_den;
      assign neg_i  = in_neg;
      assign side_i = in_side;
    end else begin : g_body
      assign vld_i  = vld_r[k-1];
      assign nsh_i  = nsh_r[k-1];
      assign q_i    = q_r[k-1];
      assign rem_i  = rem_r[k-1];
      assign den_i  = den_r[k-1];
      assign neg_i  = neg_r[k-1];
      assign side_i = side_r[k-1];
    end

    assign r2  = {rem_i, nsh_i[QW-1]};
    assign ge  = (r2 >= {1'b0, den_i});
    assign dif = r2 - {1'b0, den_i};

    always_ff @(posedge clk) begin
      if (!rst_n) begin
        vld_r[k] <= 1'b0;
      end else if (en) begin
        vld_r[k] <= vld_i;
      end
    end

    always_ff @(posedge clk) begin
      if (en) begin
        nsh_r[k]  <= nsh_i << 1;
        q_r[k]    <= {q_i[QW-2:0], ge};
        rem_r[k]  <= ge ? dif[DENW-1:0] : r2[DENW-1:0];
        den_r[k]  <= den_i;
        neg_r[k]  <= neg_i;
        side_r[k] <= side_i;
      end
    end
  end

  logic [DENW-1:0] rem_l, den_l;
  logic [QW:0]     q1, lim, mag;
  logic            neg_l, sat;

  always_comb begin
    rem_l = rem_r[QW-1];
    den_l = den_r[QW-1];
    neg_l = neg_r[QW-1];
    q1    = (QW+1)'(q_r[QW-1]) + (QW+1)'(rem_l >= (den_l - rem_l));
    lim   = ((QW+1)'(1) << (W - 1)) - (QW+1)'(!neg_l);
    sat   = (q1 > lim);
    mag   = sat ? lim : q1;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      fin_vld_r <= 1'b0;
    end else if (en) begin
      fin_vld_r <= vld_r[QW-1];
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      fin_side_r <= side_r[QW-1];
      fin_ovf_r  <= sat;
      fin_root_r <= (neg_l && (mag != '0)) ? (~mag[W-1:0] + W'(1)) : mag[W-1:0];
    end
  end

  assign out_vld  = fin_vld_r;
  assign out_root = fin_root_r;
  assign out_ovf  = fin_ovf_r;
  assign out_side = fin_side_r;

endmodule

[sv/qrs_checker.sv]
// ----------------------------------------------------------------------------
// qrs_checker
// Port-level checks for the quadratic root solver, bound to the top level.
// ----------------------------------------------------------------------------
module qrs_checker (
  input logic          clk,
  input logic          rst_n,
  input logic          out_empty,
  input logic          out_pop,
  input qrs_pkg::out_t out_data
);
  import qrs_pkg::*;

  a_reset_empty: assert property (@(posedge clk) !rst_n |=> out_empty)
    else $error("result queue not empty after reset");

  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    !out_empty && !out_pop |=> !out_empty && $stable(out_data))
    else $error("waiting result changed");

  a_no_roots_zero: assert property (@(posedge clk) disable iff (!rst_n)
    !out_empty && (out_data.root_count == CNT_NONE || out_data.root_count == CNT_ALL)
    |-> out_data.root_first == '0 && out_data.root_second == '0 && !out_data.overflow)
    else $error("root fields not zero without roots");

  a_single_same: assert property (@(posedge clk) disable iff (!rst_n)
    !out_empty && out_data.root_count == CNT_ONE
    |-> out_data.root_first == out_data.root_second)
    else $error("single root differs between fields");

endmodule

bind quadratic_root_solver qrs_checker u_qrs_checker (.*);
